>>> sv/two_stream_trigger_aligner_defines.svh
// assertion macros for the two-stream trigger aligner
// used by the controller; no other dependencies
`ifndef TWO_STREAM_TRIGGER_ALIGNER_DEFINES_SVH
`define TWO_STREAM_TRIGGER_ALIGNER_DEFINES_SVH
`ifndef SYNTH
`define TSTA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define TSTA_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define TSTA_ASSERT(lbl, clk, rstn, prop)
`define TSTA_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> sv/tsta_pkg.sv
// shared types, constants and codes of the two-stream trigger aligner
// no dependencies
`default_nettype none
package tsta_pkg;
    localparam int CLOCK_BITS_DEF    = 48;
    localparam int SEC_BITS_DEF      = 24;
    localparam int COUNT_BITS_DEF    = 32;
    localparam int CLK_IN_BITS       = 48;
    localparam int WALL_BITS         = 48;
    localparam int GAP_BITS          = 47;
    localparam int DELTA_BITS        = 47;
    localparam int TICK_BITS         = 24;
    localparam int SPLIT_BITS        = 24;
    localparam int PROD_BITS         = 48;
    localparam int NS_BITS           = 56;
    localparam int MISM_BITS         = 58;
    localparam int SKIP_BITS         = 12;
    localparam int LEFT_BITS         = 11;
    localparam int TOL_BITS          = 16;
    localparam int MASK_BITS         = 8;
    localparam int OUT_BITS          = 32;
    localparam int CFG_IDX_BITS      = 3;
    localparam int CFG_DATA_BITS     = 24;

    localparam logic [DELTA_BITS-1:0] DELTA_MAX = {DELTA_BITS{1'b1}};

    localparam logic [TOL_BITS-1:0]  TOL_RST    = 16'd300;
    localparam logic [TICK_BITS-1:0] PTICK_RST  = 24'd819200;
    localparam logic [TICK_BITS-1:0] STICK_RST  = 24'd1638408;
    localparam logic [TICK_BITS-1:0] PERIOD_RST = 24'd419433;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SKIP   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOL    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PTICK  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STICK  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD = 3'd4;

    localparam logic [2:0] V_STORED  = 3'd0;
    localparam logic [2:0] V_REF     = 3'd1;
    localparam logic [2:0] V_MATCH   = 3'd2;
    localparam logic [2:0] V_DROP_P  = 3'd3;
    localparam logic [2:0] V_DROP_S  = 3'd4;
    localparam logic [2:0] V_SKIP_P  = 3'd5;
    localparam logic [2:0] V_SKIP_S  = 3'd6;
    localparam logic [2:0] V_IGNORED = 3'd7;

    localparam logic [MASK_BITS-1:0] MASK_FLAGGED = 8'd1;

    localparam logic [1:0] MUL_P_HI = 2'd0;
    localparam logic [1:0] MUL_P_LO = 2'd1;
    localparam logic [1:0] MUL_S_HI = 2'd2;
    localparam logic [1:0] MUL_S_LO = 2'd3;

    typedef struct packed {
        logic                   source;
        logic [CLK_IN_BITS-1:0] clock_ticks;
        logic [WALL_BITS-1:0]   wall_time_us;
        logic [MASK_BITS-1:0]   trigger_mask;
    } t_in_item;

    typedef struct packed {
        logic [2:0]                verdict;
        logic                      next_source;
        logic signed [OUT_BITS-1:0] delta_mismatch_ns;
        logic [OUT_BITS-1:0]       dropped_primary;
        logic [OUT_BITS-1:0]       dropped_secondary;
        logic [OUT_BITS-1:0]       flagged_total;
        logic [OUT_BITS-1:0]       flagged_dropped;
    } t_out_item;

    typedef struct packed {
        logic       load;
        logic       classify;
        logic       prep;
        logic       wrap;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       diff;
        logic       decide;
        logic       put;
    } t_cmd;

    typedef struct packed {
        logic eval;
        logic div_done;
    } t_sts;
endpackage
`default_nettype wire

>>> sv/tsta_div.sv
// restoring divider, one quotient bit per cycle, for the wall-time wrap count
// depends on tsta_pkg
`default_nettype none
module tsta_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [tsta_pkg::GAP_BITS-1:0]   i_dividend,
    input  wire logic [tsta_pkg::TICK_BITS-1:0]  i_divisor,
    output logic                                 o_done,
    output logic [tsta_pkg::GAP_BITS-1:0]        o_quotient
);
    import tsta_pkg::*;

    localparam int CW = $clog2(GAP_BITS + 1);

    logic [GAP_BITS-1:0]  r_q;
    logic [TICK_BITS-1:0] r_rem;
    logic [TICK_BITS-1:0] r_d;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [TICK_BITS:0]   trial;
    logic                 take;

    always_comb begin
        trial = {r_rem, r_q[GAP_BITS-1]};
        take  = trial >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CW'(GAP_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (take) begin
                    r_rem <= TICK_BITS'(trial - {1'b0, r_d});
                end else begin
                    r_rem <= trial[TICK_BITS-1:0];
                end
                r_q   <= {r_q[GAP_BITS-2:0], take};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule
`default_nettype wire

>>> sv/tsta_dp.sv
// datapath: configuration, held events, references, counters, delta arithmetic
// depends on tsta_pkg and tsta_div
`default_nettype none
module tsta_dp #(
    parameter int CLOCK_BITS             = tsta_pkg::CLOCK_BITS_DEF,
    parameter int SECONDARY_COUNTER_BITS = tsta_pkg::SEC_BITS_DEF,
    parameter int COUNT_BITS             = tsta_pkg::COUNT_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire tsta_pkg::t_cmd                     i_cmd,
    output tsta_pkg::t_sts                          o_sts,
    input  wire tsta_pkg::t_in_item                 i_in_data,
    output tsta_pkg::t_out_item                     o_out_data,
    input  wire logic                               i_cfg_we,
    input  wire logic [tsta_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [tsta_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import tsta_pkg::*;

    localparam int CB  = CLOCK_BITS;
    localparam int SCB = SECONDARY_COUNTER_BITS;
    localparam int XB  = CLOCK_BITS + DELTA_BITS;

    logic                   r_src;
    logic [CLK_IN_BITS-1:0] r_clk;
    logic [WALL_BITS-1:0]   r_wall;
    logic [MASK_BITS-1:0]   r_mask;

    logic                   r_skip_neg;
    logic [LEFT_BITS-1:0]   r_skip_left;
    logic [TOL_BITS-1:0]    r_tol;
    logic [TICK_BITS-1:0]   r_ptick;
    logic [TICK_BITS-1:0]   r_stick;
    logic [TICK_BITS-1:0]   r_period;

    logic [CB-1:0]          r_ref_p;
    logic [SCB-1:0]         r_ref_s;
    logic [WALL_BITS-1:0]   r_ref_t;
    logic [CB-1:0]          r_held_p;
    logic [MASK_BITS-1:0]   r_held_m;
    logic [SCB-1:0]         r_held_s;
    logic [WALL_BITS-1:0]   r_held_t;
    logic                   r_hp;
    logic                   r_hs;
    logic                   r_have_ref;
    logic [COUNT_BITS-1:0]  r_cnt [4];
    logic [2:0]             r_verdict;
    logic                   r_eval;

    logic                   r_pneg;
    logic [DELTA_BITS-1:0]  r_pmag;
    logic [SCB-1:0]         r_base;
    logic                   r_do_wrap;
    logic [DELTA_BITS-1:0]  r_cdelta;
    logic [PROD_BITS-1:0]   r_prod;
    logic [1:0]             r_psel;
    logic                   r_pvalid;
    logic [NS_BITS-1:0]     r_pns;
    logic [NS_BITS-1:0]     r_cns;
    logic signed [MISM_BITS-1:0] r_mism;
    t_out_item              r_out;

    // result assembly
    t_out_item              n_out;
    logic                   fits32;

    // classification of the latched item
    logic                   skip_hit;
    logic                   store_p;
    logic                   store_s;
    logic                   pair;
    logic [2:0]             n_verdict;
    logic [CB-1:0]          n_held_p;
    logic [SCB-1:0]         n_held_s;
    logic [WALL_BITS-1:0]   n_held_t;
    logic                   n_hp;
    logic                   n_hs;

    always_comb begin
        skip_hit  = 1'b0;
        store_p   = 1'b0;
        store_s   = 1'b0;
        n_verdict = V_IGNORED;
        if (r_skip_left != '0) begin
            if (r_src == r_skip_neg) begin
                skip_hit  = 1'b1;
                n_verdict = r_src ? V_SKIP_S : V_SKIP_P;
            end
        end else if (!r_src && !r_hp) begin
            store_p   = 1'b1;
            n_verdict = V_STORED;
        end else if (r_src && !r_hs && r_hp) begin
            store_s   = 1'b1;
            n_verdict = V_STORED;
        end
        n_hp     = r_hp | store_p;
        n_hs     = r_hs | store_s;
        n_held_p = store_p ? CB'(r_clk) : r_held_p;
        n_held_s = store_s ? r_clk[SCB-1:0] : r_held_s;
        n_held_t = store_s ? r_wall : r_held_t;
        pair     = (store_p | store_s) & n_hp & n_hs;
    end

    // delta preparation
    logic [CB-1:0]          pv;
    logic [CB-1:0]          pm;
    logic [XB-1:0]          pm_x;
    logic [WALL_BITS-1:0]   gap;
    logic                   div_done;
    logic [GAP_BITS-1:0]    quot;

    always_comb begin
        pv   = r_held_p - r_ref_p;
        pm   = pv[CB-1] ? (~pv + CB'(1)) : pv;
        pm_x = XB'(pm);
        gap  = r_held_t - r_ref_t;
    end

    tsta_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.prep),
        .i_dividend (gap[GAP_BITS-1:0]),
        .i_divisor  (r_period),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    logic [DELTA_BITS-1:0]  base_x;
    logic [DELTA_BITS-1:0]  limit;
    logic [DELTA_BITS-1:0]  n_cdelta;

    always_comb begin
        base_x = DELTA_BITS'(r_base);
        limit  = (DELTA_MAX - base_x) >> SCB;
        if (!r_do_wrap) begin
            n_cdelta = base_x;
        end else if (quot > limit) begin
            n_cdelta = DELTA_MAX;
        end else begin
            n_cdelta = base_x + DELTA_BITS'(quot << SCB);
        end
    end

    // shared multiplier operands
    logic [TICK_BITS-1:0]   mul_a;
    logic [TICK_BITS-1:0]   mul_b;
    logic [PROD_BITS-1:0]   prod;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_P_HI: mul_a = TICK_BITS'(r_pmag[DELTA_BITS-1:SPLIT_BITS]);
            MUL_P_LO: mul_a = r_pmag[SPLIT_BITS-1:0];
            MUL_S_HI: mul_a = TICK_BITS'(r_cdelta[DELTA_BITS-1:SPLIT_BITS]);
            default:  mul_a = r_cdelta[SPLIT_BITS-1:0];
        endcase
        mul_b = i_cmd.mul_sel[1] ? r_stick : r_ptick;
        prod  = mul_a * mul_b;
    end

    // decision
    logic signed [MISM_BITS-1:0] tol_s;
    logic signed [MISM_BITS-1:0] n_mism;
    logic                   drop_p;
    logic                   drop_s;

    always_comb begin
        tol_s  = $signed(MISM_BITS'(r_tol));
        drop_p = r_mism > tol_s;
        drop_s = r_mism < -tol_s;
        if (r_pneg) begin
            n_mism = $signed(MISM_BITS'(r_cns)) + $signed(MISM_BITS'(r_pns));
        end else begin
            n_mism = $signed(MISM_BITS'(r_cns)) - $signed(MISM_BITS'(r_pns));
        end
    end

    logic [3:0] inc;

    always_comb begin
        inc[0] = (i_cmd.classify & skip_hit & !r_src) | (i_cmd.decide & drop_p);
        inc[1] = (i_cmd.classify & skip_hit & r_src) | (i_cmd.decide & !drop_p & drop_s);
        inc[2] = i_cmd.classify & store_p & (r_mask == MASK_FLAGGED);
        inc[3] = (i_cmd.classify & skip_hit & !r_src & (r_mask == MASK_FLAGGED))
               | (i_cmd.decide & drop_p & (r_held_m == MASK_FLAGGED));
    end

    // skip register decode
    logic [SKIP_BITS-1:0] skip_v;
    logic [SKIP_BITS-1:0] skip_mag;

    always_comb begin
        skip_v   = i_cfg_data[SKIP_BITS-1:0];
        skip_mag = skip_v[SKIP_BITS-1] ? (~skip_v + SKIP_BITS'(1)) : skip_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_neg  <= 1'b0;
            r_skip_left <= '0;
            r_tol       <= TOL_RST;
            r_ptick     <= PTICK_RST;
            r_stick     <= STICK_RST;
            r_period    <= PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SKIP: begin
                    r_skip_neg  <= skip_v[SKIP_BITS-1];
                    r_skip_left <= skip_mag[SKIP_BITS-1] ? {LEFT_BITS{1'b1}}
                                                         : skip_mag[LEFT_BITS-1:0];
                end
                CFG_TOL:    r_tol    <= i_cfg_data[TOL_BITS-1:0];
                CFG_PTICK:  r_ptick  <= i_cfg_data[TICK_BITS-1:0];
                CFG_STICK:  r_stick  <= i_cfg_data[TICK_BITS-1:0];
                CFG_PERIOD: r_period <= i_cfg_data[TICK_BITS-1:0];
                default: ;
            endcase
        end else if (i_cmd.classify && skip_hit) begin
            r_skip_left <= r_skip_left - LEFT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp       <= 1'b0;
            r_hs       <= 1'b0;
            r_have_ref <= 1'b0;
            r_eval     <= 1'b0;
            r_pvalid   <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                if (inc[k]) begin
                    r_cnt[k] <= r_cnt[k] + COUNT_BITS'(1);
                end
            end
            r_pvalid <= i_cmd.mul_en;
            if (i_cmd.classify) begin
                r_held_p <= n_held_p;
                r_held_s <= n_held_s;
                r_held_t <= n_held_t;
                if (store_p) begin
                    r_held_m <= r_mask;
                end
                r_eval <= pair & r_have_ref;
                if (pair && !r_have_ref) begin
                    r_verdict  <= V_REF;
                    r_have_ref <= 1'b1;
                    r_ref_p    <= n_held_p;
                    r_ref_s    <= n_held_s;
                    r_ref_t    <= n_held_t;
                    r_hp       <= 1'b0;
                    r_hs       <= 1'b0;
                end else begin
                    r_verdict <= n_verdict;
                    r_hp      <= n_hp;
                    r_hs      <= n_hs;
                end
            end
            if (i_cmd.decide) begin
                if (drop_p) begin
                    r_verdict <= V_DROP_P;
                    r_hp      <= 1'b0;
                end else if (drop_s) begin
                    r_verdict <= V_DROP_S;
                    r_hs      <= 1'b0;
                end else begin
                    r_verdict <= V_MATCH;
                    r_ref_p   <= r_held_p;
                    r_ref_s   <= r_held_s;
                    r_ref_t   <= r_held_t;
                    r_hp      <= 1'b0;
                    r_hs      <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_src  <= i_in_data.source;
            r_clk  <= i_in_data.clock_ticks;
            r_wall <= i_in_data.wall_time_us;
            r_mask <= i_in_data.trigger_mask;
        end
        if (i_cmd.prep) begin
            r_pneg    <= pv[CB-1];
            r_pmag    <= (pm_x > XB'(DELTA_MAX)) ? DELTA_MAX : pm_x[DELTA_BITS-1:0];
            r_base    <= r_held_s - r_ref_s;
            r_do_wrap <= !gap[WALL_BITS-1] && (r_period != '0)
                         && (gap > WALL_BITS'(r_period));
        end
        if (i_cmd.wrap) begin
            r_cdelta <= n_cdelta;
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod;
            r_psel <= i_cmd.mul_sel;
        end
        if (r_pvalid) begin
            case (r_psel)
                MUL_P_HI: r_pns <= NS_BITS'(r_prod) << 8;
                MUL_P_LO: r_pns <= r_pns + NS_BITS'(r_prod >> 16);
                MUL_S_HI: r_cns <= NS_BITS'(r_prod) << 8;
                default:  r_cns <= r_cns + NS_BITS'(r_prod >> 16);
            endcase
        end
        if (i_cmd.classify) begin
            r_mism <= '0;
        end
        if (i_cmd.diff) begin
            r_mism <= n_mism;
        end
        if (i_cmd.put) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        fits32 = (r_mism[MISM_BITS-1:OUT_BITS-1] == '0)
              || (r_mism[MISM_BITS-1:OUT_BITS-1] == '1);
        n_out.verdict = r_verdict;
        if (r_skip_left != '0) begin
            n_out.next_source = r_skip_neg;
        end else begin
            n_out.next_source = r_hp & !r_hs;
        end
        if (fits32) begin
            n_out.delta_mismatch_ns = r_mism[OUT_BITS-1:0];
        end else if (r_mism[MISM_BITS-1]) begin
            n_out.delta_mismatch_ns = {1'b1, {(OUT_BITS-1){1'b0}}};
        end else begin
            n_out.delta_mismatch_ns = {1'b0, {(OUT_BITS-1){1'b1}}};
        end
        n_out.dropped_primary   = OUT_BITS'(r_cnt[0]);
        n_out.dropped_secondary = OUT_BITS'(r_cnt[1]);
        n_out.flagged_total     = OUT_BITS'(r_cnt[2]);
        n_out.flagged_dropped   = OUT_BITS'(r_cnt[3]);
    end

    assign o_out_data     = r_out;
    assign o_sts.eval     = r_eval;
    assign o_sts.div_done = div_done;
endmodule
`default_nettype wire

>>> sv/tsta_ctrl.sv
// controller state machine: sequences classify, divide, multiply and decide steps
// depends on tsta_pkg and the assertion macro header
`default_nettype none
`include "two_stream_trigger_aligner_defines.svh"
module tsta_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output tsta_pkg::t_cmd      o_cmd,
    input  wire tsta_pkg::t_sts i_sts
);
    import tsta_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_CHK, S_DIV_GO, S_DIV_WAIT, S_WRAP,
        S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_ACC, S_DIFF, S_DEC, S_PUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   in_acc;
    logic   put_ok;

    always_comb begin
        in_acc  = (r_state == S_IDLE) && i_in_valid;
        put_ok  = !r_out_valid || !i_out_stall;
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_CLASS;
            end
            S_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: n_state = i_sts.eval ? S_DIV_GO : S_PUT;
            S_DIV_GO: begin
                o_cmd.prep = 1'b1;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: if (i_sts.div_done) n_state = S_WRAP;
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P_HI;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P_LO;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_S_HI;
                n_state = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_S_LO;
                n_state = S_ACC;
            end
            S_ACC: n_state = S_DIFF;
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state = S_PUT;
            end
            S_PUT: begin
                o_cmd.put = put_ok;
                if (put_ok) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.put) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `TSTA_ASSERT(a_load_to_class, i_clk, i_rst_n, in_acc |=> r_state == S_CLASS)
    `TSTA_NEVER(a_put_overrun, i_clk, i_rst_n, o_cmd.put && r_out_valid && i_out_stall)
    `TSTA_ASSERT(a_done_in_wait, i_clk, i_rst_n, i_sts.div_done |-> r_state == S_DIV_WAIT)
endmodule
`default_nettype wire

>>> sv/two_stream_trigger_aligner.sv
// top level of the two-stream trigger aligner: controller, datapath, config port
// depends on tsta_pkg, tsta_ctrl and tsta_dp
//
// One item is handled at a time. An item that does not complete a pair goes from
// classify through a check straight to the put step, and the next item is taken
// once its result is put. One that completes a pair after the first reference
// also runs the bit-serial divider that counts extra secondary counter wraps,
// the wrap step, four passes of a shared 24x24 multiplier, accumulate, difference
// and decide before its put. A finished result sits in an output register, so
// the next item is accepted while it waits; output stall holds an item's put
// step only while the previous result is still waiting.
// Configuration writes are always ready.
`default_nettype none
module two_stream_trigger_aligner #(
    parameter int CLOCK_BITS             = tsta_pkg::CLOCK_BITS_DEF,
    parameter int SECONDARY_COUNTER_BITS = tsta_pkg::SEC_BITS_DEF,
    parameter int COUNT_BITS             = tsta_pkg::COUNT_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire tsta_pkg::t_in_item                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output tsta_pkg::t_out_item                     o_out_data,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [tsta_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [tsta_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import tsta_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tsta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    tsta_dp #(
        .CLOCK_BITS             (CLOCK_BITS),
        .SECONDARY_COUNTER_BITS (SECONDARY_COUNTER_BITS),
        .COUNT_BITS             (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    assign o_cfg_ready = 1'b1;
endmodule
`default_nettype wire

>>> tb/sv/two_stream_trigger_aligner_test.sv
// self-checking bench for the two-stream trigger aligner: directed and random event
// streams, an in-bench alignment predictor, random idling and stalls on both sides
// depends on tsta_pkg and two_stream_trigger_aligner
`timescale 1ns / 1ps
module two_stream_trigger_aligner_test;
    import tsta_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    two_stream_trigger_aligner i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor state
    int          skip_cfg = 0;
    int          skip_left = 0;
    logic [63:0] tol_ns = TOL_RST;
    logic [63:0] ptick = PTICK_RST;
    logic [63:0] stick = STICK_RST;
    logic [63:0] period = PERIOD_RST;
    logic [63:0] ref_pclk = 0, ref_scnt = 0, ref_wall = 0;
    logic [63:0] held_pclk = 0, held_scnt = 0, held_wall = 0;
    logic [7:0]  held_mask = 0;
    bit          have_p = 0, have_s = 0, have_ref = 0;
    logic [31:0] drop_cnt [4] = '{default: 0};

    t_in_item  event_queue [$];
    t_out_item predicted_results [$];
    int  in_idle = 0, out_idle = 0;
    int  hold_cnt = 0;
    bit  hold_go = 0;
    int  errors = 0;
    int  results_seen = 0;
    int  verdict_seen [8] = '{default: 0};
    longint cycles = 0;

    function automatic logic [63:0] to_ns(logic [63:0] mag, logic [63:0] tick);
        return (((mag >> 24) * tick) << 8) + (((mag & 64'hFFFFFF) * tick) >> 16);
    endfunction

    function automatic logic awaited();
        if (skip_left > 0) return skip_cfg < 0;
        if (!have_p) return 1'b0;
        if (!have_s) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [23:0] d);
        case (idx)
            CFG_SKIP: begin
                skip_cfg = int'($signed(d[11:0]));
                skip_left = (skip_cfg < 0) ? -skip_cfg : skip_cfg;
                if (skip_left > 2047) skip_left = 2047;
            end
            CFG_TOL:    tol_ns = d[15:0];
            CFG_PTICK:  ptick = d;
            CFG_STICK:  stick = d;
            CFG_PERIOD: period = d;
            default: ;
        endcase
    endfunction

    function automatic t_out_item align_event(t_in_item ev);
        t_out_item r;
        logic [63:0] dmax, pv, pmag, base, gap, cdelta, n, lim;
        bit pneg;
        longint pd, ch, mism;
        dmax = 64'h7FFF_FFFF_FFFF;
        r = '0;
        r.verdict = V_IGNORED;
        mism = 0;
        if (skip_left > 0) begin
            if (ev.source == (skip_cfg < 0)) begin
                skip_left--;
                if (!ev.source) begin
                    drop_cnt[0]++;
                    if (ev.trigger_mask == MASK_FLAGGED) drop_cnt[3]++;
                    r.verdict = V_SKIP_P;
                end else begin
                    drop_cnt[1]++;
                    r.verdict = V_SKIP_S;
                end
            end
        end else if (!ev.source && !have_p) begin
            held_pclk = ev.clock_ticks;
            held_mask = ev.trigger_mask;
            have_p = 1;
            if (ev.trigger_mask == MASK_FLAGGED) drop_cnt[2]++;
            r.verdict = V_STORED;
        end else if (ev.source && !have_s && have_p) begin
            held_scnt = ev.clock_ticks[23:0];
            held_wall = ev.wall_time_us;
            have_s = 1;
            r.verdict = V_STORED;
        end
        if (r.verdict == V_STORED && have_p && have_s) begin
            if (!have_ref) begin
                r.verdict = V_REF;
                have_ref = 1;
                ref_pclk = held_pclk;
                ref_scnt = held_scnt;
                ref_wall = held_wall;
                have_p = 0;
                have_s = 0;
            end else begin
                pv = (held_pclk - ref_pclk) & 64'hFFFF_FFFF_FFFF;
                pneg = pv[47];
                pmag = pneg ? ((~pv + 1) & 64'hFFFF_FFFF_FFFF) : pv;
                if (pmag > dmax) pmag = dmax;
                pd = pneg ? -longint'(to_ns(pmag, ptick)) : longint'(to_ns(pmag, ptick));
                base = (held_scnt - ref_scnt) & 64'hFF_FFFF;
                cdelta = base;
                gap = (held_wall - ref_wall) & 64'hFFFF_FFFF_FFFF;
                if (!gap[47] && period != 0 && gap > period) begin
                    n = gap / period;
                    lim = (dmax - base) >> 24;
                    cdelta = (n > lim) ? dmax : base + (n << 24);
                end
                if (cdelta > dmax) cdelta = dmax;
                ch = longint'(to_ns(cdelta, stick));
                mism = ch - pd;
                if (mism > longint'(tol_ns)) begin
                    r.verdict = V_DROP_P;
                    drop_cnt[0]++;
                    if (held_mask == MASK_FLAGGED) drop_cnt[3]++;
                    have_p = 0;
                end else if (mism < -longint'(tol_ns)) begin
                    r.verdict = V_DROP_S;
                    drop_cnt[1]++;
                    have_s = 0;
                end else begin
                    r.verdict = V_MATCH;
                    ref_pclk = held_pclk;
                    ref_scnt = held_scnt;
                    ref_wall = held_wall;
                    have_p = 0;
                    have_s = 0;
                end
            end
        end
        if (mism > 64'sd2147483647) mism = 64'sd2147483647;
        if (mism < -64'sd2147483648) mism = -64'sd2147483648;
        r.next_source = awaited();
        r.delta_mismatch_ns = mism[31:0];
        r.dropped_primary = drop_cnt[0];
        r.dropped_secondary = drop_cnt[1];
        r.flagged_total = drop_cnt[2];
        r.flagged_dropped = drop_cnt[3];
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) predicted_results.push_back(align_event(i_in_data));
            if (event_queue.size() > 0 && $urandom_range(99) >= in_idle) begin
                i_in_valid <= 1'b1;
                i_in_data <= event_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
        else if (hold_go) hold_cnt <= 600;
    end

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display("mismatch on %s at item %0d: expected %0h, got %0h",
                         name, results_seen, want, got);
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (predicted_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("result with no item pending");
                end else begin
                    want = predicted_results.pop_front();
                    check_field("verdict", 32'(o_out_data.verdict), 32'(want.verdict));
                    check_field("next_source", 32'(o_out_data.next_source),
                                32'(want.next_source));
                    check_field("delta_mismatch_ns", o_out_data.delta_mismatch_ns,
                                want.delta_mismatch_ns);
                    check_field("dropped_primary", o_out_data.dropped_primary,
                                want.dropped_primary);
                    check_field("dropped_secondary", o_out_data.dropped_secondary,
                                want.dropped_secondary);
                    check_field("flagged_total", o_out_data.flagged_total, want.flagged_total);
                    check_field("flagged_dropped", o_out_data.flagged_dropped,
                                want.flagged_dropped);
                    verdict_seen[want.verdict]++;
                end
                results_seen++;
            end
            i_out_stall <= (hold_cnt > 0) || ($urandom_range(99) < out_idle);
        end
    end

    task automatic push_event(logic src, logic [47:0] clk, logic [47:0] wall, logic [7:0] m);
        t_in_item ev;
        ev.source = src;
        ev.clock_ticks = clk;
        ev.wall_time_us = wall;
        ev.trigger_mask = m;
        event_queue.push_back(ev);
    endtask

    function automatic logic [7:0] rand_mask();
        return ($urandom_range(99) < 30) ? MASK_FLAGGED : 8'($urandom);
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // timeline of one trigger source seen by both streams, with faults mixed in
    longint trig_t = 0;
    logic [47:0] p_off = 0, s_off = 0, w_off = 0;

    task automatic add_trigger_stream(int count);
        int k, r;
        longint jit;
        logic [47:0] pclk, scnt, wall;
        p_off = rand48();
        s_off = rand48();
        w_off = rand48();
        k = 0;
        while (k < count) begin
            trig_t += ($urandom_range(99) < 90) ? longint'($urandom_range(2000000, 100))
                                                : longint'($urandom_range(1000)) * 1000000;
            jit = ($urandom_range(99) < 6) ? longint'($urandom_range(100)) - 50 : 0;
            pclk = p_off + 48'(trig_t * 2 / 25);
            scnt = s_off + 48'(trig_t / 25 + jit);
            wall = w_off + 48'(trig_t / 1000);
            r = $urandom_range(99);
            if (r < 80) begin
                push_event(1'b0, pclk, rand48(), rand_mask());
                push_event(1'b1, scnt, wall, 8'($urandom));
                k += 2;
            end else if (r < 87) begin
                push_event(1'b0, pclk, rand48(), rand_mask());
                k++;
            end else if (r < 94) begin
                push_event(1'b1, scnt, wall, 8'($urandom));
                k++;
            end else begin
                push_event(1'($urandom), rand48(), rand48(), rand_mask());
                k++;
            end
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [23:0] d);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_cfg(idx, d);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_skip(int n);
        logic [11:0] s;
        s = 12'(n);
        cfg_write(CFG_SKIP, {12'd0, s});
    endtask

    task automatic set_default_ticks();
        cfg_write(CFG_TOL, 24'(TOL_RST));
        cfg_write(CFG_PTICK, PTICK_RST);
        cfg_write(CFG_STICK, STICK_RST);
        cfg_write(CFG_PERIOD, PERIOD_RST);
    endtask

    task automatic drain(int ip, int op);
        in_idle <= ip;
        out_idle <= op;
        do @(posedge i_clk);
        while (event_queue.size() != 0 || i_in_valid || predicted_results.size() != 0);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed events under reset settings
        push_event(1'b1, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'hFF);
        push_event(1'b0, 48'h0, 48'h0, MASK_FLAGGED);
        push_event(1'b0, 48'hFFFF_FFFF_FFFF, 48'h0, 8'h00);
        push_event(1'b1, 48'h0, 48'h0, 8'h00);
        push_event(1'b1, 48'h0, 48'h0, 8'h00);
        push_event(1'b0, 48'd80000, 48'h0, 8'hFF);
        push_event(1'b1, 48'd40000, 48'd1000, 8'h00);
        push_event(1'b0, 48'd80100, 48'h0, MASK_FLAGGED);
        push_event(1'b1, 48'd50000, 48'd1200, 8'h00);
        push_event(1'b0, 48'd200000, 48'h0, MASK_FLAGGED);
        push_event(1'b1, 48'd40000, 48'd1600, 8'h00);
        push_event(1'b1, 48'd60000, 48'd2400, 8'h00);
        push_event(1'b0, 48'd20, 48'h0, 8'h00);
        push_event(1'b1, 48'hFFFFFF, 48'hFFFF_FFFF_0000, 8'h00);
        push_event(1'b0, 48'd100000000, 48'h0, 8'h02);
        push_event(1'b1, 48'hFFFF_FF00_0000, 48'h7FFF_0000_0000, 8'h00);
        push_event(1'b0, 48'h8000_0000_0000, 48'h0, MASK_FLAGGED);
        push_event(1'b1, 48'h12345, 48'h0000_0100_0000, 8'h00);
        push_event(1'b0, 48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'h80);
        push_event(1'b1, 48'h0, 48'h8000_0000_0000, 8'h00);
        drain(0, 0);

        // skipping in both directions, small and large counts
        set_skip(3);
        add_trigger_stream(20);
        drain(0, 0);
        set_skip(-2);
        add_trigger_stream(15);
        drain(0, 0);
        set_skip(1024);
        add_trigger_stream(8);
        drain(0, 0);
        set_skip(-1024);
        add_trigger_stream(8);
        drain(0, 0);
        set_skip(0);

        add_trigger_stream(400);
        drain(0, 0);

        cfg_write(CFG_TOL, 24'd0);
        cfg_write(CFG_PTICK, 24'($urandom_range(1638400, 409600)));
        cfg_write(CFG_STICK, 24'($urandom_range(3276800, 819200)));
        cfg_write(CFG_PERIOD, 24'($urandom_range(24'hFFFFFF, 1)));
        add_trigger_stream(300);
        drain(75, 0);

        cfg_write(CFG_TOL, 24'hFFFF);
        cfg_write(CFG_PTICK, 24'hFFFFFF);
        cfg_write(CFG_STICK, 24'd1);
        cfg_write(CFG_PERIOD, 24'hFFFFFF);
        add_trigger_stream(200);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        drain(0, 75);

        // zero tick and zero wrap period
        cfg_write(CFG_PERIOD, 24'd0);
        cfg_write(CFG_STICK, 24'd0);
        cfg_write(CFG_PTICK, 24'd1);
        add_trigger_stream(100);
        drain(30, 30);

        set_default_ticks();
        set_skip(5);
        add_trigger_stream(500);
        drain(30, 30);
        set_skip(-7);
        add_trigger_stream(300);
        drain(0, 0);

        repeat (200) @(posedge i_clk);
        $display("covered %0d results: stored %0d, reference %0d, matched %0d",
                 results_seen, verdict_seen[V_STORED], verdict_seen[V_REF],
                 verdict_seen[V_MATCH]);
        $display("drops p/s %0d/%0d, skips p/s %0d/%0d, ignored %0d, %0d field mismatches",
                 verdict_seen[V_DROP_P], verdict_seen[V_DROP_S], verdict_seen[V_SKIP_P],
                 verdict_seen[V_SKIP_S], verdict_seen[V_IGNORED], errors);
        if (errors == 0 && predicted_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+sv
sv/tsta_pkg.sv
sv/tsta_div.sv
sv/tsta_dp.sv
sv/tsta_ctrl.sv
sv/two_stream_trigger_aligner.sv
tb/sv/two_stream_trigger_aligner_test.sv
